/* design/bpdc_pkg.sv */
`timescale 1ns / 1ps
package bpdc_pkg;

	// Sizes
	localparam int COUNT_WIDTH = 8;
	localparam int TIME_WIDTH  = 32;
	localparam int LIMIT_W     = 16;
	localparam int STAMP_W     = 32;
	localparam int OUT_CNT_W   = 8;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	// Register reset values
	localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 16'd500;
	localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 16'd2000;
	localparam logic [LIMIT_W-1:0] VLONG_LIMIT_RST = 16'd5000;

	typedef logic [TIME_WIDTH-1:0]  time_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_SHORT_LIMIT = 2'd0,
		REG_LONG_LIMIT  = 2'd1,
		REG_VLONG_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		PH_NONE = 2'd0,
		PH_PUSH = 2'd1,
		PH_PULL = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CL_NONE  = 2'd0,
		CL_SHORT = 2'd1,
		CL_LONG  = 2'd2,
		CL_VLONG = 2'd3
	} press_class_t;

	typedef enum logic {
		ACT_EDGE = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic {
		RK_RELEASE = 1'b0,
		RK_SEQ_END = 1'b1
	} report_kind_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] short_limit_ms;
		logic [LIMIT_W-1:0] long_limit_ms;
		logic [LIMIT_W-1:0] very_long_limit_ms;
	} cfg_t;

	typedef struct packed {
		logic               action;
		logic               pin_level;
		logic [STAMP_W-1:0] now_ms;
	} evt_item_t;

	typedef struct packed {
		logic                 report_kind;
		logic [1:0]           press_class;
		logic [OUT_CNT_W-1:0] short_presses;
		logic [OUT_CNT_W-1:0] long_presses;
		logic [OUT_CNT_W-1:0] very_long_presses;
		logic                 led_on;
	} rpt_item_t;

	// Saturating increment
	function automatic count_t bump(input count_t c);
		bump = (c == '1) ? c : count_t'(c + 1'b1);
	endfunction

	// Counter to 8-bit report field (zero-extend or truncate)
	function automatic logic [OUT_CNT_W-1:0] cnt_out(input count_t c);
		logic [COUNT_WIDTH+OUT_CNT_W-1:0] ext;
		ext = {{OUT_CNT_W{1'b0}}, c};
		cnt_out = ext[OUT_CNT_W-1:0];
	endfunction

	// elapsed > limit, unsigned, at full width of both
	function automatic logic past_limit(input time_t elapsed, input logic [LIMIT_W-1:0] lim);
		logic [TIME_WIDTH+LIMIT_W-1:0] e_w;
		logic [TIME_WIDTH+LIMIT_W-1:0] l_w;
		e_w = {{LIMIT_W{1'b0}}, elapsed};
		l_w = {{TIME_WIDTH{1'b0}}, lim};
		past_limit = (e_w > l_w);
	endfunction

endpackage

/* design/bpdc_ifs.sv */
`timescale 1ns / 1ps
interface bpdc_evt_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic        pin_level;
	logic [31:0] now_ms;

	modport source (output valid, action, pin_level, now_ms, input ready);
	modport sink   (input valid, action, pin_level, now_ms, output ready);
endinterface

interface bpdc_rpt_if;
	logic       valid;
	logic       ready;
	logic       report_kind;
	logic [1:0] press_class;
	logic [7:0] short_presses;
	logic [7:0] long_presses;
	logic [7:0] very_long_presses;
	logic       led_on;

	modport source (output valid, report_kind, press_class, short_presses, long_presses,
		very_long_presses, led_on, input ready);
	modport sink   (input valid, report_kind, press_class, short_presses, long_presses,
		very_long_presses, led_on, output ready);
endinterface

/* design/bpdc_regs.sv */
`timescale 1ns / 1ps
module bpdc_regs
	import bpdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;

	// Limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_limit_ms     <= SHORT_LIMIT_RST;
			cfg_q.long_limit_ms      <= LONG_LIMIT_RST;
			cfg_q.very_long_limit_ms <= VLONG_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_SHORT_LIMIT: cfg_q.short_limit_ms     <= pwdata[LIMIT_W-1:0];
				REG_LONG_LIMIT:  cfg_q.long_limit_ms      <= pwdata[LIMIT_W-1:0];
				REG_VLONG_LIMIT: cfg_q.very_long_limit_ms <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (idx)
			REG_SHORT_LIMIT: prdata = {{(APB_DW-LIMIT_W){1'b0}}, cfg_q.short_limit_ms};
			REG_LONG_LIMIT:  prdata = {{(APB_DW-LIMIT_W){1'b0}}, cfg_q.long_limit_ms};
			REG_VLONG_LIMIT: prdata = {{(APB_DW-LIMIT_W){1'b0}}, cfg_q.very_long_limit_ms};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* design/bpdc_core.sv */
`timescale 1ns / 1ps
module bpdc_core
	import bpdc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      fire,
	input  evt_item_t item,
	output logic      res_valid,
	output rpt_item_t res
);

	phase_t       phase_q, phase_d;
	press_class_t cls_q, cls_d;
	time_t        start_q, start_d;
	count_t       short_q, short_d;
	count_t       long_q, long_d;
	count_t       vlong_q, vlong_d;
	logic         seq_q, seq_d;
	logic         to_q, to_d;
	logic         tick_q, tick_d;
	logic         led_q, led_d;

	time_t now;
	time_t elapsed;
	logic  seq_end;

	assign now     = item.now_ms[TIME_WIDTH-1:0];
	assign elapsed = now - start_q;

	// Step logic for the item in the input stage
	always_comb begin
		phase_d = phase_q;
		cls_d   = cls_q;
		start_d = start_q;
		short_d = short_q;
		long_d  = long_q;
		vlong_d = vlong_q;
		seq_d   = seq_q;
		to_d    = to_q;
		tick_d  = tick_q;
		led_d   = led_q;
		seq_end = 1'b0;
		res_valid = 1'b0;
		res = '0;

		if (item.action == ACT_EDGE) begin
			if (!item.pin_level) begin
				// press
				led_d   = 1'b1;
				phase_d = PH_PUSH;
				seq_d   = 1'b1;
				start_d = now;
				tick_d  = 1'b1;
			end else begin
				// release: count by class, always report
				led_d = 1'b0;
				if (seq_q) begin
					case (cls_q)
						CL_SHORT: short_d = bump(short_q);
						CL_LONG:  long_d  = bump(long_q);
						CL_VLONG: vlong_d = bump(vlong_q);
						default: ;
					endcase
				end
				res_valid             = 1'b1;
				res.report_kind       = RK_RELEASE;
				res.press_class       = cls_q;
				res.short_presses     = cnt_out(short_d);
				res.long_presses      = cnt_out(long_d);
				res.very_long_presses = cnt_out(vlong_d);
				res.led_on            = 1'b0;
				cls_d   = CL_NONE;
				phase_d = PH_PULL;
				seq_d   = 1'b1;
				start_d = now;
				if (!to_q) tick_d = 1'b1;
				else       to_d   = 1'b0;
			end
		end else if (tick_q) begin
			case (phase_q)
				PH_PUSH: begin
					if (cls_q == CL_NONE) begin
						cls_d = CL_SHORT;
					end else if (past_limit(elapsed, cfg.short_limit_ms) && cls_q == CL_SHORT) begin
						cls_d = CL_LONG;
					end else if (past_limit(elapsed, cfg.long_limit_ms) && cls_q == CL_LONG) begin
						cls_d = CL_VLONG;
					end else if (past_limit(elapsed, cfg.very_long_limit_ms)) begin
						seq_end = 1'b1;
						to_d    = 1'b1;
					end
				end
				PH_PULL: begin
					if (past_limit(elapsed, cfg.short_limit_ms)) seq_end = 1'b1;
				end
				default: ;
			endcase
		end

		// Sequence end: report totals, then clear
		if (seq_end) begin
			res_valid             = 1'b1;
			res.report_kind       = RK_SEQ_END;
			res.press_class       = CL_NONE;
			res.short_presses     = cnt_out(short_q);
			res.long_presses      = cnt_out(long_q);
			res.very_long_presses = cnt_out(vlong_q);
			res.led_on            = led_q;
			tick_d  = 1'b0;
			cls_d   = CL_NONE;
			short_d = '0;
			long_d  = '0;
			vlong_d = '0;
			seq_d   = 1'b0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
			cls_q   <= CL_NONE;
			start_q <= '0;
			short_q <= '0;
			long_q  <= '0;
			vlong_q <= '0;
			seq_q   <= 1'b0;
			to_q    <= 1'b0;
			tick_q  <= 1'b0;
			led_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			cls_q   <= cls_d;
			start_q <= start_d;
			short_q <= short_d;
			long_q  <= long_d;
			vlong_q <= vlong_d;
			seq_q   <= seq_d;
			to_q    <= to_d;
			tick_q  <= tick_d;
			led_q   <= led_d;
		end
	end

endmodule

/* design/button_press_duration_classifier.sv */
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// evt      in   valid/ready    action, pin_level, now_ms
// rpt      out  valid/ready    report_kind, press_class, short/long/very_long_presses, led_on
// apb      in   psel/penable   short_limit_ms @0x0, long_limit_ms @0x4, very_long_limit_ms @0x8
//
// One item per cycle unless a result is stalled: input register, one pass of step logic
// (32-bit subtract and limit compares), result register. An event beat is captured in
// the input register, and its result is registered when the step logic advances.
// A stalled result holds only items that give a result; other items keep flowing.
// Reset (arst_n low) clears all state and loads the limit defaults; no clearing pass.
module button_press_duration_classifier
	import bpdc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	bpdc_evt_if.sink          evt,
	bpdc_rpt_if.source        rpt,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	cfg_t      cfg;
	evt_item_t evt_s1;
	logic      evt_v_s1;
	rpt_item_t res;
	logic      res_valid;
	rpt_item_t rpt_q;
	logic      rpt_v_q;
	logic      out_free;
	logic      s1_adv;
	logic      evt_acc;

	bpdc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpdc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (s1_adv),
		.item      (evt_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Flow control
	assign out_free  = !rpt_v_q || rpt.ready;
	assign s1_adv    = evt_v_s1 && (!res_valid || out_free);
	assign evt.ready = !evt_v_s1 || s1_adv;
	assign evt_acc   = evt.valid && evt.ready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_v_s1 <= 1'b0;
		end else if (evt.ready) begin
			evt_v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_acc) begin
			evt_s1.action    <= evt.action;
			evt_s1.pin_level <= evt.pin_level;
			evt_s1.now_ms    <= evt.now_ms;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_v_q <= 1'b0;
		end else if (out_free) begin
			rpt_v_q <= s1_adv && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_adv && res_valid) begin
			rpt_q <= res;
		end
	end

	assign rpt.valid             = rpt_v_q;
	assign rpt.report_kind       = rpt_q.report_kind;
	assign rpt.press_class       = rpt_q.press_class;
	assign rpt.short_presses     = rpt_q.short_presses;
	assign rpt.long_presses      = rpt_q.long_presses;
	assign rpt.very_long_presses = rpt_q.very_long_presses;
	assign rpt.led_on            = rpt_q.led_on;

endmodule

/* design/bpdc_checker.sv */
`timescale 1ns / 1ps
module bpdc_checker
	import bpdc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic       rpt_valid,
	input logic       rpt_ready,
	input logic       report_kind,
	input logic [1:0] press_class,
	input logic       led_on
);

	logic evt_acc;
	assign evt_acc = evt_valid && evt_ready;

	// Result beat holds until taken
	a_rpt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=> rpt_valid)
		else $error("rpt valid dropped before taken");

	// Checks that a new result follows an accepted event beat
	a_rpt_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rpt_valid) |-> $past(evt_acc, 2))
		else $error("result without a matching event beat");

	// Sequence-end reports carry no press class
	a_end_class: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && report_kind == RK_SEQ_END |-> press_class == CL_NONE)
		else $error("sequence end with a press class");

	// Release reports show the LED off
	a_release_led: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && report_kind == RK_RELEASE |-> !led_on)
		else $error("release report with LED on");

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.evt_valid   (evt.valid),
	.evt_ready   (evt.ready),
	.rpt_valid   (rpt.valid),
	.rpt_ready   (rpt.ready),
	.report_kind (rpt.report_kind),
	.press_class (rpt.press_class),
	.led_on      (rpt.led_on)
);
